// ===== rtl/activity_max_heap_top_defines.svh =====
// Assertion macros for the activity max-heap RTL.
`ifndef ACTIVITY_MAX_HEAP_TOP_DEFINES_SVH
`define ACTIVITY_MAX_HEAP_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define AMH_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define AMH_ASSERT(lbl, prop, msg)
`define AMH_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== rtl/amh_pkg.sv =====
// Shared constants for the activity max-heap.
`timescale 1ns / 1ps
package amh_pkg;
    localparam int VAR_W      = 10;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 2;
    localparam int IN_ACT_W   = 32;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PRESENT     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_PRESENT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY   = 2'd3;
endpackage

// ===== rtl/amh_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module amh_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/amh_seq.sv =====
// Heap sequencer: command decode, sift up/down over the RAMs, result register.
`timescale 1ns / 1ps
`include "activity_max_heap_top_defines.svh"
module amh_seq #(
    parameter int NUM_VARS  = 1024,
    parameter int ACT_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [amh_pkg::CMD_W-1:0]     s_cmd,
    input  logic [amh_pkg::VAR_W-1:0]     s_var,
    input  logic [amh_pkg::IN_ACT_W-1:0]  s_act,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [amh_pkg::VAR_W-1:0]     m_popped,
    output logic                          m_in_heap,
    output logic                          m_empty,
    output logic [amh_pkg::STAT_W-1:0]    m_status,
    output logic                          hp_we,
    output logic [$clog2(NUM_VARS)-1:0]   hp_waddr,
    output logic [amh_pkg::VAR_W-1:0]     hp_wdata,
    output logic [$clog2(NUM_VARS)-1:0]   hp_raddr,
    input  logic [amh_pkg::VAR_W-1:0]     hp_rdata,
    output logic                          ps_we,
    output logic [$clog2(NUM_VARS)-1:0]   ps_waddr,
    output logic [$clog2(NUM_VARS):0]     ps_wdata,
    output logic [$clog2(NUM_VARS)-1:0]   ps_raddr,
    input  logic [$clog2(NUM_VARS):0]     ps_rdata,
    output logic                          ac_we,
    output logic [$clog2(NUM_VARS)-1:0]   ac_waddr,
    output logic [ACT_WIDTH-1:0]          ac_wdata,
    output logic [$clog2(NUM_VARS)-1:0]   ac_raddr,
    input  logic [ACT_WIDTH-1:0]          ac_rdata
);
    localparam int IW = $clog2(NUM_VARS);
    localparam int CW = $clog2(NUM_VARS + 1);
    localparam int VW = amh_pkg::VAR_W;
    localparam int SW = amh_pkg::STAT_W;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_CHK     = 5'd2;
    localparam logic [4:0] S_UP_TEST = 5'd3;
    localparam logic [4:0] S_UP_PAR  = 5'd4;
    localparam logic [4:0] S_UP_CMP  = 5'd5;
    localparam logic [4:0] S_P_TOP   = 5'd6;
    localparam logic [4:0] S_P_LAST  = 5'd7;
    localparam logic [4:0] S_P_ACT   = 5'd8;
    localparam logic [4:0] S_D_TEST  = 5'd9;
    localparam logic [4:0] S_D_L     = 5'd10;
    localparam logic [4:0] S_D_R     = 5'd11;
    localparam logic [4:0] S_D_RA    = 5'd12;
    localparam logic [4:0] S_D_DEC   = 5'd13;
    localparam logic [4:0] S_FIN     = 5'd14;
    localparam logic [4:0] S_RES     = 5'd15;
    localparam logic [4:0] S_OUT     = 5'd16;

    logic [4:0]           state_reg, state_next;
    logic [IW-1:0]        clr_reg, clr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 m_valid_reg, m_valid_next;

    logic [amh_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [VW-1:0]        var_reg, var_next;
    logic                 vin_reg, vin_next;
    logic [ACT_WIDTH-1:0] act_in_reg, act_in_next;
    logic [IW-1:0]        slot_reg, slot_next;
    logic [VW-1:0]        item_reg, item_next;
    logic [ACT_WIDTH-1:0] item_act_reg, item_act_next;
    logic [VW-1:0]        top_reg, top_next;
    logic [VW-1:0]        pick_v_reg, pick_v_next;
    logic [ACT_WIDTH-1:0] pick_a_reg, pick_a_next;
    logic [IW-1:0]        pick_s_reg, pick_s_next;
    logic [VW-1:0]        lv_reg, lv_next;
    logic [ACT_WIDTH-1:0] la_reg, la_next;
    logic [SW-1:0]        status_reg, status_next;
    logic [VW-1:0]        popped_reg, popped_next;
    logic [VW-1:0]        m_popped_reg, m_popped_next;
    logic                 m_in_heap_reg, m_in_heap_next;
    logic                 m_empty_reg, m_empty_next;
    logic [SW-1:0]        m_status_reg, m_status_next;

    logic [CW:0]          left_w;
    logic [CW:0]          right_w;
    logic                 pos_v;
    logic [ACT_WIDTH-1:0] raised;

    assign left_w   = {(CW + 1 - IW)'(0), slot_reg} + {(CW + 1 - IW)'(0), slot_reg}
                      + (CW + 1)'(1);
    assign right_w  = left_w + (CW + 1)'(1);
    assign pos_v    = ps_rdata[IW];
    assign raised   = (act_in_reg > ac_rdata) ? act_in_reg : ac_rdata;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg;
        cmd_next       = cmd_reg;
        var_next       = var_reg;
        vin_next       = vin_reg;
        act_in_next    = act_in_reg;
        slot_next      = slot_reg;
        item_next      = item_reg;
        item_act_next  = item_act_reg;
        top_next       = top_reg;
        pick_v_next    = pick_v_reg;
        pick_a_next    = pick_a_reg;
        pick_s_next    = pick_s_reg;
        lv_next        = lv_reg;
        la_next        = la_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        m_popped_next  = m_popped_reg;
        m_in_heap_next = m_in_heap_reg;
        m_empty_next   = m_empty_reg;
        m_status_next  = m_status_reg;

        hp_we    = 1'b0;
        hp_waddr = slot_reg;
        hp_wdata = item_reg;
        hp_raddr = '0;
        ps_we    = 1'b0;
        ps_waddr = IW'(item_reg);
        ps_wdata = {1'b1, slot_reg};
        ps_raddr = IW'(var_reg);
        ac_we    = 1'b0;
        ac_waddr = IW'(var_reg);
        ac_wdata = act_in_reg;
        ac_raddr = IW'(var_reg);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR: begin
                ps_we    = 1'b1;
                ps_waddr = clr_reg;
                ps_wdata = '0;
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'(NUM_VARS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                ps_raddr = IW'(s_var);
                ac_raddr = IW'(s_var);
                if (s_tvalid) begin
                    cmd_next    = s_cmd;
                    var_next    = s_var;
                    vin_next    = (32'(s_var) < NUM_VARS);
                    act_in_next = ACT_WIDTH'(s_act);
                    status_next = amh_pkg::STAT_OK;
                    popped_next = '0;
                    if (s_cmd == amh_pkg::CMD_POP) begin
                        if (count_reg == '0) begin
                            status_next = amh_pkg::STAT_POP_EMPTY;
                            state_next  = S_RES;
                        end else begin
                            state_next = S_P_TOP;
                        end
                    end else begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK: begin
                state_next = S_RES;
                case (cmd_reg)
                    amh_pkg::CMD_INSERT: begin
                        if (!vin_reg) begin
                            status_next = amh_pkg::STAT_NOT_PRESENT;
                        end else if (pos_v) begin
                            status_next = amh_pkg::STAT_PRESENT;
                        end else begin
                            ac_we         = 1'b1;
                            item_next     = var_reg;
                            item_act_next = act_in_reg;
                            slot_next     = IW'(count_reg);
                            count_next    = count_reg + CW'(1);
                            state_next    = S_UP_TEST;
                        end
                    end
                    amh_pkg::CMD_UPDATE: begin
                        if (!vin_reg || !pos_v) begin
                            status_next = amh_pkg::STAT_NOT_PRESENT;
                        end else begin
                            ac_we         = 1'b1;
                            ac_wdata      = raised;
                            item_next     = var_reg;
                            item_act_next = raised;
                            slot_next     = ps_rdata[IW-1:0];
                            state_next    = S_UP_TEST;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_UP_TEST: begin
                hp_raddr    = (slot_reg - IW'(1)) >> 1;
                pick_s_next = (slot_reg - IW'(1)) >> 1;
                state_next  = (slot_reg == '0) ? S_FIN : S_UP_PAR;
            end
            S_UP_PAR: begin
                pick_v_next = hp_rdata;
                ac_raddr    = IW'(hp_rdata);
                state_next  = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (item_act_reg > ac_rdata) begin
                    hp_we      = 1'b1;
                    hp_wdata   = pick_v_reg;
                    ps_we      = 1'b1;
                    ps_waddr   = IW'(pick_v_reg);
                    slot_next  = pick_s_reg;
                    state_next = S_UP_TEST;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_P_TOP: begin
                top_next   = hp_rdata;
                hp_raddr   = IW'(count_reg - CW'(1));
                state_next = S_P_LAST;
            end
            S_P_LAST: begin
                item_next  = hp_rdata;
                ac_raddr   = IW'(hp_rdata);
                state_next = S_P_ACT;
            end
            S_P_ACT: begin
                item_act_next = ac_rdata;
                ps_we         = 1'b1;
                ps_waddr      = IW'(top_reg);
                ps_wdata      = '0;
                count_next    = count_reg - CW'(1);
                popped_next   = top_reg;
                slot_next     = '0;
                state_next    = (count_reg == CW'(1)) ? S_RES : S_D_TEST;
            end
            S_D_TEST: begin
                hp_raddr    = IW'(left_w);
                pick_s_next = IW'(left_w);
                if (left_w >= (CW + 1)'(count_reg)) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_D_L;
                end
            end
            S_D_L: begin
                lv_next    = hp_rdata;
                ac_raddr   = IW'(hp_rdata);
                hp_raddr   = IW'(right_w);
                state_next = S_D_R;
            end
            S_D_R: begin
                la_next = ac_rdata;
                if (right_w < (CW + 1)'(count_reg)) begin
                    pick_v_next = hp_rdata;
                    ac_raddr    = IW'(hp_rdata);
                    state_next  = S_D_RA;
                end else begin
                    pick_v_next = lv_reg;
                    pick_a_next = ac_rdata;
                    pick_s_next = IW'(left_w);
                    state_next  = S_D_DEC;
                end
            end
            S_D_RA: begin
                if (ac_rdata > la_reg) begin
                    pick_a_next = ac_rdata;
                    pick_s_next = IW'(right_w);
                end else begin
                    pick_v_next = lv_reg;
                    pick_a_next = la_reg;
                    pick_s_next = IW'(left_w);
                end
                state_next = S_D_DEC;
            end
            S_D_DEC: begin
                if (item_act_reg > pick_a_reg) begin
                    state_next = S_FIN;
                end else begin
                    hp_we      = 1'b1;
                    hp_wdata   = pick_v_reg;
                    ps_we      = 1'b1;
                    ps_waddr   = IW'(pick_v_reg);
                    slot_next  = pick_s_reg;
                    state_next = S_D_TEST;
                end
            end
            S_FIN: begin
                hp_we      = 1'b1;
                ps_we      = 1'b1;
                state_next = S_RES;
            end
            S_RES: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next   = 1'b1;
                    m_popped_next  = popped_reg;
                    m_in_heap_next = vin_reg && pos_v;
                    m_empty_next   = (count_reg == '0);
                    m_status_next  = status_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            clr_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        var_reg       <= var_next;
        vin_reg       <= vin_next;
        act_in_reg    <= act_in_next;
        slot_reg      <= slot_next;
        item_reg      <= item_next;
        item_act_reg  <= item_act_next;
        top_reg       <= top_next;
        pick_v_reg    <= pick_v_next;
        pick_a_reg    <= pick_a_next;
        pick_s_reg    <= pick_s_next;
        lv_reg        <= lv_next;
        la_reg        <= la_next;
        status_reg    <= status_next;
        popped_reg    <= popped_next;
        m_popped_reg  <= m_popped_next;
        m_in_heap_reg <= m_in_heap_next;
        m_empty_reg   <= m_empty_next;
        m_status_reg  <= m_status_next;
    end

    assign m_tvalid  = m_valid_reg;
    assign m_popped  = m_popped_reg;
    assign m_in_heap = m_in_heap_reg;
    assign m_empty   = m_empty_reg;
    assign m_status  = m_status_reg;

    `AMH_ASSERT(a_count_max, count_reg <= CW'(NUM_VARS), "heap count above capacity")
    `AMH_ASSERT(a_out_src, $rose(m_tvalid) |-> $past(state_reg == S_OUT), "result not from S_OUT")
    `AMH_ASSERT(a_take_busy, s_tvalid && s_tready |=> state_reg != S_IDLE, "accepted beat ignored")
    `AMH_ASSERT_RST(a_rst_clr, !aresetn |=> state_reg == S_CLR && !m_tvalid, "reset not clearing")
endmodule

// ===== rtl/activity_max_heap_top.sv =====
// Top level of the indexed activity max-heap: stream ports, RAMs and sequencer.
`timescale 1ns / 1ps
// Indexed binary max-heap of variables keyed by activity. After reset the
// position map is swept clear, one entry per cycle, over all NUM_VARS entries
// with s_tready low. Each beat is then handled alone by a sequencer over three
// RAMs with registered reads (heap slots, position map, activities): insert and
// update sift the item up a level at a time, pop moves the last item to the
// root and sifts it down. The single read port on each RAM serialises the reads
// at each heap level. A finished result waits in the output register while the
// next beat is taken.
module activity_max_heap_top #(
    parameter int NUM_VARS  = 1024,
    parameter int ACT_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // var_index[9:0], activity_value[41:10], zero fill
    input  logic [amh_pkg::S_TDATA_W-1:0]    s_tdata,
    // command[1:0]
    input  logic [amh_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // popped_var[9:0], in_heap[10], is_empty[11], status[13:12], zero fill
    output logic [amh_pkg::M_TDATA_W-1:0]    m_tdata
);
    localparam int IW = $clog2(NUM_VARS);
    localparam int VW = amh_pkg::VAR_W;

    logic                      hp_we, ps_we, ac_we;
    logic [IW-1:0]             hp_waddr, hp_raddr, ps_waddr, ps_raddr, ac_waddr, ac_raddr;
    logic [VW-1:0]             hp_wdata, hp_rdata;
    logic [IW:0]               ps_wdata, ps_rdata;
    logic [ACT_WIDTH-1:0]      ac_wdata, ac_rdata;
    logic [VW-1:0]             m_popped;
    logic                      m_in_heap, m_empty;
    logic [amh_pkg::STAT_W-1:0] m_status;

    amh_ram #(.W(VW), .D(NUM_VARS)) u_heap_ram (
        .aclk(aclk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
        .raddr(hp_raddr), .rdata(hp_rdata)
    );

    amh_ram #(.W(IW + 1), .D(NUM_VARS)) u_pos_ram (
        .aclk(aclk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
        .raddr(ps_raddr), .rdata(ps_rdata)
    );

    amh_ram #(.W(ACT_WIDTH), .D(NUM_VARS)) u_act_ram (
        .aclk(aclk), .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
        .raddr(ac_raddr), .rdata(ac_rdata)
    );

    amh_seq #(.NUM_VARS(NUM_VARS), .ACT_WIDTH(ACT_WIDTH)) u_seq (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_cmd(s_tuser[amh_pkg::CMD_W-1:0]),
        .s_var(s_tdata[VW-1:0]),
        .s_act(s_tdata[VW+amh_pkg::IN_ACT_W-1:VW]),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_popped(m_popped),
        .m_in_heap(m_in_heap),
        .m_empty(m_empty),
        .m_status(m_status),
        .hp_we(hp_we), .hp_waddr(hp_waddr), .hp_wdata(hp_wdata),
        .hp_raddr(hp_raddr), .hp_rdata(hp_rdata),
        .ps_we(ps_we), .ps_waddr(ps_waddr), .ps_wdata(ps_wdata),
        .ps_raddr(ps_raddr), .ps_rdata(ps_rdata),
        .ac_we(ac_we), .ac_waddr(ac_waddr), .ac_wdata(ac_wdata),
        .ac_raddr(ac_raddr), .ac_rdata(ac_rdata)
    );

    assign m_tdata = {2'b00, m_status, m_empty, m_in_heap, m_popped};
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the activity max-heap: directed table, random ops, scoreboard.
`timescale 1ns / 1ps
module tb;
    localparam int NV = 1024;
    localparam int SLW = amh_pkg::VAR_W + 1;

    typedef struct packed {
        logic [amh_pkg::VAR_W-1:0]  popped;
        logic                       in_heap;
        logic                       empty;
        logic [amh_pkg::STAT_W-1:0] status;
    } heap_res_t;

    typedef struct {
        logic [amh_pkg::CMD_W-1:0] cmd;
        logic [amh_pkg::VAR_W-1:0] var_id;
        logic [31:0]               act;
        bit                        has_exp;
        heap_res_t                 exp_res;
    } dir_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [amh_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [amh_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [amh_pkg::M_TDATA_W-1:0] m_tdata;

    activity_max_heap_top dut (.*);

    always #10 aclk = ~aclk;

    // predictor state
    logic [amh_pkg::VAR_W-1:0] slot_var [NV];
    logic [amh_pkg::VAR_W:0]   var_slot [NV];
    bit                        var_in   [NV];
    logic [31:0]               act_of   [NV];
    int                        count;

    heap_res_t pending_q [$];
    heap_res_t typed_q [$];
    bit        typed_flag_q [$];
    int errors = 0;
    bit stim_done = 0;
    bit rand_sink = 1;
    int sink_hold = 0;

    function automatic void heap_swap_up(int s);
        logic [amh_pkg::VAR_W-1:0] it;
        int p;
        it = slot_var[s];
        while (s != 0) begin
            p = (s - 1) >> 1;
            if (!(act_of[it] > act_of[slot_var[p]])) break;
            slot_var[s] = slot_var[p];
            var_slot[slot_var[p]] = SLW'(s);
            s = p;
        end
        slot_var[s] = it;
        var_slot[it] = SLW'(s);
    endfunction

    function automatic void heap_swap_down(int s);
        logic [amh_pkg::VAR_W-1:0] it;
        int l, pk;
        it = slot_var[s];
        forever begin
            l = 2 * s + 1;
            if (l >= count) break;
            pk = l;
            if (l + 1 < count && act_of[slot_var[l+1]] > act_of[slot_var[l]]) pk = l + 1;
            if (act_of[it] > act_of[slot_var[pk]]) break;
            slot_var[s] = slot_var[pk];
            var_slot[slot_var[s]] = SLW'(s);
            s = pk;
        end
        slot_var[s] = it;
        var_slot[it] = SLW'(s);
    endfunction

    function automatic heap_res_t heap_apply(logic [amh_pkg::CMD_W-1:0] cmd,
                                             logic [amh_pkg::VAR_W-1:0] v,
                                             logic [31:0] a);
        heap_res_t r;
        logic [amh_pkg::VAR_W-1:0] top;
        r = '0;
        case (cmd)
            amh_pkg::CMD_INSERT: begin
                if (var_in[v]) r.status = amh_pkg::STAT_PRESENT;
                else begin
                    act_of[v] = a;
                    slot_var[count] = v;
                    var_slot[v] = SLW'(count);
                    var_in[v] = 1;
                    count++;
                    heap_swap_up(count - 1);
                end
            end
            amh_pkg::CMD_UPDATE: begin
                if (!var_in[v]) r.status = amh_pkg::STAT_NOT_PRESENT;
                else begin
                    if (a > act_of[v]) act_of[v] = a;
                    heap_swap_up(int'(var_slot[v]));
                end
            end
            amh_pkg::CMD_POP: begin
                if (count == 0) r.status = amh_pkg::STAT_POP_EMPTY;
                else begin
                    top = slot_var[0];
                    slot_var[0] = slot_var[count-1];
                    var_slot[slot_var[0]] = '0;
                    var_in[top] = 0;
                    count--;
                    if (count > 1) heap_swap_down(0);
                    r.popped = top;
                end
            end
            default: ;
        endcase
        r.in_heap = var_in[v];
        r.empty = (count == 0);
        return r;
    endfunction

    task automatic send_beat(logic [amh_pkg::CMD_W-1:0] cmd, logic [amh_pkg::VAR_W-1:0] v,
                             logic [31:0] a, bit has_exp, heap_res_t ex);
        heap_res_t p;
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, a, v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = heap_apply(cmd, v, a);
        pending_q.push_back(p);
        typed_q.push_back(ex);
        typed_flag_q.push_back(has_exp);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3))
                @(posedge aclk);
        end
    endtask

    function automatic heap_res_t mk(logic [amh_pkg::VAR_W-1:0] pv, bit ih, bit em,
                                     logic [amh_pkg::STAT_W-1:0] st);
        heap_res_t r;
        r.popped = pv; r.in_heap = ih; r.empty = em; r.status = st;
        return r;
    endfunction

    // result side
    always @(posedge aclk) begin
        heap_res_t got, ex, ty;
        bit tf;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.popped  = m_tdata[9:0];
                got.in_heap = m_tdata[10];
                got.empty   = m_tdata[11];
                got.status  = m_tdata[13:12];
                if (pending_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    ex = pending_q.pop_front();
                    ty = typed_q.pop_front();
                    tf = typed_flag_q.pop_front();
                    if (tf && ty != ex) begin
                        $error("table row disagrees with predictor: %h vs %h", ty, ex);
                        errors++;
                    end
                    if (got.popped !== ex.popped) begin
                        $error("popped_var exp %0d got %0d", ex.popped, got.popped); errors++;
                    end
                    if (got.in_heap !== ex.in_heap) begin
                        $error("in_heap exp %0d got %0d", ex.in_heap, got.in_heap); errors++;
                    end
                    if (got.empty !== ex.empty) begin
                        $error("is_empty exp %0d got %0d", ex.empty, got.empty); errors++;
                    end
                    if (got.status !== ex.status) begin
                        $error("status exp %0d got %0d", ex.status, got.status); errors++;
                    end
                end
            end
            if (!rand_sink) m_tready <= 1;
            else if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                m_tready <= 0;
            end else if ($urandom_range(0, 49) == 0) begin
                sink_hold <= int'($urandom_range(5, 60));
                m_tready <= 0;
            end else if ($urandom_range(0, 19) == 0) m_tready <= 0;
            else if ($urandom_range(0, 2) != 0) m_tready <= 1;
        end
    end

    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        dir_row_t tbl [$];
        dir_row_t row;
        logic [amh_pkg::CMD_W-1:0] c;
        logic [amh_pkg::VAR_W-1:0] v;
        logic [31:0] a;
        int k, n, cnt;
        for (k = 0; k < NV; k++) begin
            var_in[k] = 0; act_of[k] = '0; slot_var[k] = '0; var_slot[k] = '0;
        end
        count = 0;
        // directed table
        tbl.push_back('{amh_pkg::CMD_POP, 10'd0, 32'd0, 1'b1,
                        mk(10'd0, 1'b0, 1'b1, amh_pkg::STAT_POP_EMPTY)});
        tbl.push_back('{amh_pkg::CMD_QUERY, 10'd1023, 32'hFFFFFFFF, 1'b1,
                        mk(10'd0, 1'b0, 1'b1, amh_pkg::STAT_OK)});
        tbl.push_back('{amh_pkg::CMD_UPDATE, 10'd5, 32'd7, 1'b1,
                        mk(10'd0, 1'b0, 1'b1, amh_pkg::STAT_NOT_PRESENT)});
        tbl.push_back('{amh_pkg::CMD_INSERT, 10'd1023, 32'hFFFFFFFF, 1'b1,
                        mk(10'd0, 1'b1, 1'b0, amh_pkg::STAT_OK)});
        tbl.push_back('{amh_pkg::CMD_INSERT, 10'd1023, 32'd1, 1'b1,
                        mk(10'd0, 1'b1, 1'b0, amh_pkg::STAT_PRESENT)});
        tbl.push_back('{amh_pkg::CMD_INSERT, 10'd0, 32'd0, 1'b1,
                        mk(10'd0, 1'b1, 1'b0, amh_pkg::STAT_OK)});
        tbl.push_back('{amh_pkg::CMD_INSERT, 10'd3, 32'd100, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_INSERT, 10'd4, 32'd100, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_INSERT, 10'd5, 32'd50, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_UPDATE, 10'd5, 32'd10, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_UPDATE, 10'd0, 32'd200, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_UPDATE, 10'd4, 32'hFFFFFFFF, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_QUERY, 10'd3, 32'd0, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_POP, 10'd3, 32'd0, 1'b1,
                        mk(10'd1023, 1'b1, 1'b0, amh_pkg::STAT_OK)});
        for (k = 0; k < 5; k++) tbl.push_back('{amh_pkg::CMD_POP, 10'd0, 32'd0, 1'b0, '0});
        tbl.push_back('{amh_pkg::CMD_POP, 10'd0, 32'd0, 1'b1,
                        mk(10'd0, 1'b0, 1'b1, amh_pkg::STAT_POP_EMPTY)});

        repeat (11) @(posedge aclk);
        aresetn <= 1;
        foreach (tbl[i]) begin
            row = tbl[i];
            send_beat(row.cmd, row.var_id, row.act, row.has_exp, row.exp_res);
        end

        for (n = 0; n < 1900; n++) begin
            if (n == 900) begin
                s_tvalid <= 0;
                while (pending_q.size() != 0) @(posedge aclk);
            end
            if (n == 1200) rand_sink = 0;
            if (n == 1500) rand_sink = 1;
            // bias insert vs pop so heap size wanders, occasionally draining it
            cnt = count;
            k = $urandom_range(0, 99);
            if (((n / 300) % 2 == 0) ? k < 45 : k < 20) c = amh_pkg::CMD_INSERT;
            else if (k < 60) c = amh_pkg::CMD_UPDATE;
            else if (k < 90) c = amh_pkg::CMD_POP;
            else c = amh_pkg::CMD_QUERY;
            if (cnt > 0 && $urandom_range(0, 2) != 0 && c != amh_pkg::CMD_INSERT)
                v = slot_var[$urandom_range(0, cnt - 1)];
            else if ($urandom_range(0, 1)) v = amh_pkg::VAR_W'($urandom_range(0, 63));
            else v = amh_pkg::VAR_W'($urandom);
            case ($urandom_range(0, 3))
                0: a = $urandom_range(0, 15);
                1: a = $urandom;
                2: a = 32'hFFFFFFFF - $urandom_range(0, 3);
                default: a = $urandom_range(0, 1000);
            endcase
            send_beat(c, v, a, 0, '0);
        end
        s_tvalid <= 0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_q.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/amh_pkg.sv
rtl/amh_ram.sv
rtl/amh_seq.sv
rtl/activity_max_heap_top.sv
tb/tb.sv
